### design/assert_macros.svh
// assertion macros used by the checker file bbm_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BBM_ASSERT_IMP(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BBM_ASSERT_NXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

### design/bbm_pkg.sv
// shared types and constants of the box blur mean filter
// no dependencies
package bbm_pkg;

   // configuration register file
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;
   localparam int CFG_SIZE_BITS  = 11;
   localparam int CFG_RADIUS_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RADIUS       = 2'd2;

   localparam logic [CFG_SIZE_BITS-1:0]   RESET_IMAGE_WIDTH  = 11'd1024;
   localparam logic [CFG_SIZE_BITS-1:0]   RESET_IMAGE_HEIGHT = 11'd1024;
   localparam logic [CFG_RADIUS_BITS-1:0] RESET_RADIUS       = 2'd1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic mem_rd;    // request accepted: latch pixel, read line store column
      logic col_step;  // write back column, shift in column sum
      logic win_step;  // add up the window column sums
      logic mul_step;  // multiply window sum by reciprocal
      logic out_load;  // load the result register
   } dp_cmd_type;

endpackage

### design/bbm_datapath.sv
// datapath: line store, column sums, window sum and divide by reciprocal
// depends on bbm_pkg
module bbm_datapath #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 3,
   parameter int PIXEL_BITS = 8
) (
   input  logic                          clock,
   input  bbm_pkg::dp_cmd_type           cmd,
   input  logic [$clog2(MAX_WIDTH)-1:0]  col_addr,
   input  logic [$clog2(2*MAX_RADIUS+1)-1:0] slot,
   input  logic [$clog2(MAX_RADIUS+1)-1:0]   eff_radius,
   input  logic [PIXEL_BITS-1:0]         pixel_in,
   output logic [PIXEL_BITS-1:0]         pixel_out
);

   localparam int MAX_SIDE = 2 * MAX_RADIUS + 1;
   localparam int CB  = $clog2(MAX_WIDTH);
   localparam int SB  = $clog2(MAX_SIDE);
   localparam int RB  = $clog2(MAX_RADIUS + 1);
   localparam int CSB = PIXEL_BITS + $clog2(MAX_SIDE);
   localparam int WSB = PIXEL_BITS + $clog2(MAX_SIDE * MAX_SIDE);
   localparam int K   = WSB + 8;
   localparam int RW  = K + 1;
   localparam int PW  = WSB + RW;
   localparam int WORD_BITS = MAX_SIDE * PIXEL_BITS;

   // one word per column holds that column of every row slot
   logic [WORD_BITS-1:0] line_store [MAX_WIDTH];

   logic [WORD_BITS-1:0]  rd_word_ff;
   logic [PIXEL_BITS-1:0] pix_ff;
   logic [WORD_BITS-1:0]  new_word;
   logic [CSB-1:0]        col_sum;
   logic [CSB-1:0]        col_regs_ff [MAX_SIDE];
   logic [WSB-1:0]        win_in;
   logic [WSB-1:0]        win_ff;
   logic [PW-1:0]         prod_ff;
   logic [PIXEL_BITS-1:0] pix_out_ff;
   logic [RB:0]           two_d;
   logic [RW-1:0]         recip_table [MAX_RADIUS+1];

   assign two_d = {eff_radius, 1'b0};

   // ceil(2^K / side^2) is exact for every window sum that can occur
   for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_recip
      localparam longint unsigned DIV = longint'((2 * g + 1) * (2 * g + 1));
      localparam longint unsigned RCP = ((64'd1 << K) + DIV - 64'd1) / DIV;
      assign recip_table[g] = RW'(RCP);
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_word_ff <= line_store[col_addr];
         pix_ff     <= pixel_in;
      end
      if (cmd.col_step) begin
         line_store[col_addr] <= new_word;
      end
   end

   // insert the new pixel into its slot and sum the active slots
   always_comb begin
      logic [PIXEL_BITS-1:0] cur;
      col_sum  = '0;
      new_word = rd_word_ff;
      for (int s = 0; s < MAX_SIDE; s++) begin
         if (SB'(s) == slot) begin
            cur = pix_ff;
         end else begin
            cur = rd_word_ff[s*PIXEL_BITS +: PIXEL_BITS];
         end
         new_word[s*PIXEL_BITS +: PIXEL_BITS] = cur;
         if (s <= int'(two_d)) begin
            col_sum = col_sum + CSB'(cur);
         end
      end
   end

   always_comb begin
      win_in = '0;
      for (int j = 0; j < MAX_SIDE; j++) begin
         if (j <= int'(two_d)) begin
            win_in = win_in + WSB'(col_regs_ff[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.col_step) begin
         col_regs_ff[0] <= col_sum;
         for (int j = 1; j < MAX_SIDE; j++) begin
            col_regs_ff[j] <= col_regs_ff[j-1];
         end
      end
      if (cmd.win_step) begin
         win_ff <= win_in;
      end
      if (cmd.mul_step) begin
         prod_ff <= PW'(win_ff) * PW'(recip_table[eff_radius]);
      end
      if (cmd.out_load) begin
         pix_out_ff <= prod_ff[K +: PIXEL_BITS];
      end
   end

   assign pixel_out = pix_out_ff;

endmodule

### design/bbm_ctrl.sv
// controller: configuration registers, frame counters, sequencing, output handshake
// depends on bbm_pkg
module bbm_ctrl #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bbm_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bbm_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output bbm_pkg::dp_cmd_type                   cmd,
   output logic [$clog2(MAX_WIDTH)-1:0]          col_addr,
   output logic [$clog2(2*MAX_RADIUS+1)-1:0]     slot,
   output logic [$clog2(MAX_RADIUS+1)-1:0]       eff_radius
);

   localparam int CB = $clog2(MAX_WIDTH);
   localparam int HB0 = $clog2(MAX_HEIGHT);
   localparam int WB = $clog2(MAX_WIDTH + 1);
   localparam int HB = $clog2(MAX_HEIGHT + 1);
   localparam int RB = $clog2(MAX_RADIUS + 1);
   localparam int SB = $clog2(2 * MAX_RADIUS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_COL  = 3'd1;
   localparam logic [2:0] ST_WIN  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [bbm_pkg::CFG_SIZE_BITS-1:0]   width_ff, height_ff;
   logic [bbm_pkg::CFG_RADIUS_BITS-1:0] radius_ff;
   logic [CB-1:0]  col_ff;
   logic [HB0-1:0] row_ff;
   logic [SB-1:0]  slot_ff;
   logic           emit_ff, emit_in;
   logic           last_ff, last_in;
   logic           rsp_valid_ff, rsp_last_ff;
   logic [WB-1:0]  eff_w;
   logic [HB-1:0]  eff_h;
   logic [RB:0]    two_d;
   logic           accept, csr_write, col_wrap, row_wrap, out_free;

   assign accept    = req_tvalid && req_tready;
   // register writes only between pixels, and they win over a request in the same cycle
   assign csr_ready = (state_ff == ST_IDLE);
   assign csr_write = csr_valid && csr_ready;

   // clamp the configured geometry to the supported range
   always_comb begin
      if (width_ff == '0) begin
         eff_w = WB'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = WB'(MAX_WIDTH);
      end else begin
         eff_w = WB'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HB'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = HB'(MAX_HEIGHT);
      end else begin
         eff_h = HB'(height_ff);
      end
      if (32'(radius_ff) > 32'(MAX_RADIUS)) begin
         eff_radius = RB'(MAX_RADIUS);
      end else begin
         eff_radius = RB'(radius_ff);
      end
   end

   assign two_d    = {eff_radius, 1'b0};
   assign col_wrap = (WB'(col_ff) == eff_w - WB'(1));
   assign row_wrap = (HB'(row_ff) == eff_h - HB'(1));
   assign emit_in  = (WB'(col_ff) >= WB'(two_d)) && (HB'(row_ff) >= HB'(two_d));
   assign last_in  = col_wrap && row_wrap;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mem_rd   = accept;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_COL;
            end
         end
         ST_COL: begin
            cmd.col_step = 1'b1;
            state_in     = ST_WIN;
         end
         ST_WIN: begin
            cmd.win_step = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            // hold here only while a result must go out and the register is full
            if (!emit_ff || out_free) begin
               cmd.out_load = emit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= bbm_pkg::RESET_IMAGE_WIDTH;
         height_ff    <= bbm_pkg::RESET_IMAGE_HEIGHT;
         radius_ff    <= bbm_pkg::RESET_RADIUS;
         col_ff       <= '0;
         row_ff       <= '0;
         slot_ff      <= '0;
         emit_ff      <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            emit_ff <= emit_in;
            last_ff <= last_in;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_last_ff  <= last_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            unique case (csr_index)
               bbm_pkg::REG_IMAGE_WIDTH: begin
                  width_ff <= csr_wdata;
               end
               bbm_pkg::REG_IMAGE_HEIGHT: begin
                  height_ff <= csr_wdata;
               end
               bbm_pkg::REG_RADIUS: begin
                  radius_ff <= csr_wdata[bbm_pkg::CFG_RADIUS_BITS-1:0];
               end
               default: begin
               end
            endcase
            // any known register restarts the frame
            if (csr_index == bbm_pkg::REG_IMAGE_WIDTH || csr_index == bbm_pkg::REG_IMAGE_HEIGHT
                || csr_index == bbm_pkg::REG_RADIUS) begin
               col_ff  <= '0;
               row_ff  <= '0;
               slot_ff <= '0;
            end
         end else if (cmd.col_step) begin
            if (col_wrap) begin
               col_ff <= '0;
               if (row_wrap) begin
                  row_ff  <= '0;
                  slot_ff <= '0;
               end else begin
                  row_ff  <= row_ff + HB0'(1);
                  slot_ff <= (slot_ff == SB'(two_d)) ? '0 : slot_ff + SB'(1);
               end
            end else begin
               col_ff <= col_ff + CB'(1);
            end
         end
      end
   end

   assign col_addr   = col_ff;
   assign slot       = slot_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### design/box_blur_mean_filter_core.sv
// Box blur mean filter, valid region only.
// Pixels of a grayscale frame enter in raster order on the req_ stream. For every
// pixel that completes a (2*radius+1) square window the block returns the window
// mean, truncated, on the rsp_ stream; rsp_tlast marks the last result of a frame.
// Frames give (height-2*radius) x (width-2*radius) results; none when a side is
// not larger than 2*radius. Registers on the csr_ port: 0 image_width,
// 1 image_height, 2 radius; each write restarts the frame and is taken only while
// the block is idle.
// The controller steps each pixel through a line store read, a read-modify-write
// of the column word with column sum, the window sum, the reciprocal multiply and
// the result register, and takes the next request only once it is back in idle.
// A result shows on rsp_tvalid as the result register is loaded.
// A stalled receiver holds the result register; the next request is still taken
// and worked on, and waits at the last step only if it must produce a result.
// Synchronous reset clears counters, handshake state and registers to 1024 x 1024,
// radius 1. The line store needs no clearing: every read that feeds a result
// covers rows already written in the current frame.
// Depends on bbm_pkg, bbm_ctrl and bbm_datapath.
module box_blur_mean_filter_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_RADIUS = 3,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((PIXEL_BITS+7)/8)*8-1:0]     req_tdata,   // pixel_in
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((PIXEL_BITS+7)/8)*8-1:0]     rsp_tdata,   // pixel_out
   output logic                                rsp_tlast,   // end_of_frame
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bbm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bbm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int TDATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;

   bbm_pkg::dp_cmd_type                  cmd;
   logic [$clog2(MAX_WIDTH)-1:0]         col_addr;
   logic [$clog2(2*MAX_RADIUS+1)-1:0]    slot;
   logic [$clog2(MAX_RADIUS+1)-1:0]      eff_radius;
   logic [PIXEL_BITS-1:0]                pixel_out;

   bbm_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .col_addr   (col_addr),
      .slot       (slot),
      .eff_radius (eff_radius)
   );

   bbm_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .col_addr   (col_addr),
      .slot       (slot),
      .eff_radius (eff_radius),
      .pixel_in   (req_tdata[PIXEL_BITS-1:0]),
      .pixel_out  (pixel_out)
   );

   assign rsp_tdata = TDATA_BITS'(pixel_out);

endmodule

### design/bbm_checker.sv
// port-level checks of the box blur mean filter, bound to the top level
// depends on assert_macros.svh and box_blur_mean_filter_core
`include "assert_macros.svh"

module bbm_checker #(
   parameter int TDATA_BITS = 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [TDATA_BITS-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   logic req_acc;
   logic rsp_stall;

   assign req_acc   = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // one request at a time: ready drops right after an accept
   `BBM_ASSERT_NXT(a_one_in_flight, clock, reset, req_acc, !req_tready, "ready after accept")

   // a result never appears in the cycle after its request
   `BBM_ASSERT_IMP(a_min_latency, clock, reset, $rose(rsp_tvalid), !$past(req_acc), "early result")

   // stalled result keeps valid and payload
   `BBM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid, "stalled valid dropped")
   `BBM_ASSERT_NXT(a_data_hold, clock, reset, rsp_stall, $stable(rsp_tdata), "data moved")
   `BBM_ASSERT_NXT(a_last_hold, clock, reset, rsp_stall, $stable(rsp_tlast), "last moved")

endmodule

bind box_blur_mean_filter_core bbm_checker #(
   .TDATA_BITS (((PIXEL_BITS + 7) / 8) * 8)
) u_bbm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
